[sv/hrrip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrip_pkg
// Shared types, codes and default sizes of the hybrid RRIP replacement unit.
// ----------------------------------------------------------------------------
package hrrip_pkg;

   localparam int DEF_NUM_SETS      = 2048;
   localparam int DEF_NUM_WAYS      = 16;
   localparam int DEF_LEADER_COUNT  = 64;
   localparam int DEF_SELECTOR_BITS = 10;
   localparam int DEF_DECAY_PERIOD  = 8192;
   localparam int DEF_HISTORY_DEPTH = 4;

   localparam int SET_IN_W  = 11;
   localparam int WAY_IN_W  = 4;
   localparam int ADDR_W    = 48;
   localparam int PC_W      = 64;
   localparam int SIG_W     = 6;
   localparam int SIG_SHIFT = 13;
   localparam int SIG_DEPTH = 64;
   localparam int CTR_W     = 2;
   localparam int RRPV_W    = 2;
   localparam int BIM_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 3;

   localparam logic [CTR_W-1:0]  CTR_MAX   = 2'd3;
   localparam logic [CTR_W-1:0]  CTR_INIT  = 2'd1;
   localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

   localparam logic [1:0] REUSE_RESET  = 2'd1;
   localparam logic [2:0] STREAM_RESET = 3'd3;

   typedef enum logic [1:0] {
      CODE_ZERO = 2'd0,
      CODE_POS  = 2'd1,
      CODE_NEG  = 2'd2
   } sign_code_type;

   typedef enum logic {
      OP_VICTIM = 1'b0,
      OP_UPDATE = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REUSE  = 1'b0,
      CSR_STREAM = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_VICTIM,
      ST_EVAL,
      ST_CTR_A,
      ST_CTR_B
   } state_type;

endpackage
`default_nettype wire

[sv/hrrip_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrip_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hrrip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[sv/hrrip_victim.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrip_victim
// Victim search over one set: first dead way, else first distant way,
// else age the set and search again.
// ----------------------------------------------------------------------------
module hrrip_victim import hrrip_pkg::*; #(
   parameter int NUM_WAYS = DEF_NUM_WAYS
) (
   input  wire logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv,
   input  wire logic [NUM_WAYS-1:0]             dead,
   output      logic [$clog2(NUM_WAYS)-1:0]     victim_way,
   output      logic                            age,
   output      logic [NUM_WAYS-1:0][RRPV_W-1:0] aged_rrpv
);
   localparam int WAY_W = $clog2(NUM_WAYS);

   logic                found_dead, found_far, found_aged;
   logic [WAY_W-1:0]    dead_way, far_way, aged_way;

   always_comb begin
      found_dead = 1'b0;
      found_far  = 1'b0;
      found_aged = 1'b0;
      dead_way   = '0;
      far_way    = '0;
      aged_way   = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (dead[w]) begin
            found_dead = 1'b1;
            dead_way   = WAY_W'(w);
         end
         if (rrpv[w] == RRPV_MAX) begin
            found_far = 1'b1;
            far_way   = WAY_W'(w);
         end
         if (rrpv[w] == RRPV_MAX - 2'd1) begin
            found_aged = 1'b1;
            aged_way   = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_rrpv[w] = (rrpv[w] == RRPV_MAX) ? rrpv[w] : rrpv[w] + 2'd1;
      end
      age = !found_dead && !found_far;
      priority if (found_dead) begin
         victim_way = dead_way;
      end else if (found_far) begin
         victim_way = far_way;
      end else if (found_aged) begin
         victim_way = aged_way;
      end else begin
         victim_way = '0;
      end
   end
endmodule
`default_nettype wire

[sv/hrrip_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrip_stream
// Per-set stream detector: record the delta sign, advance the history
// pointer and test the sign counts against the threshold.
// ----------------------------------------------------------------------------
module hrrip_stream import hrrip_pkg::*; #(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  wire logic [ADDR_W-1:0]                   address,
   input  wire logic [ADDR_W-1:0]                   last_address,
   input  wire logic [HISTORY_DEPTH-1:0][1:0]       signs,
   input  wire logic [$clog2(HISTORY_DEPTH)-1:0]    pointer,
   input  wire logic [CSR_DAT_W-1:0]                threshold,
   output      logic [HISTORY_DEPTH-1:0][1:0]       signs_next,
   output      logic [$clog2(HISTORY_DEPTH)-1:0]    pointer_next,
   output      logic                                streaming
);
   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1) + 1;

   sign_code_type      code;
   logic [CNT_W-1:0]   pos, neg, total, thr;

   always_comb begin
      if (address > last_address) begin
         code = CODE_POS;
      end else if (address < last_address) begin
         code = CODE_NEG;
      end else begin
         code = CODE_ZERO;
      end
      signs_next   = signs;
      pointer_next = pointer;
      if (last_address != '0) begin
         signs_next[pointer] = code;
         pointer_next = (pointer == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : pointer + 1'b1;
      end
      pos = '0;
      neg = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (signs_next[i] == CODE_POS) begin
            pos = pos + 1'b1;
         end else if (signs_next[i] == CODE_NEG) begin
            neg = neg + 1'b1;
         end
      end
      total     = pos + neg;
      thr       = CNT_W'(threshold);
      streaming = (total >= thr) && ((pos >= thr) || (neg >= thr));
   end
endmodule
`default_nettype wire

[sv/hybrid_rrip_cache_replacement_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_rrip_cache_replacement_unit
// LLC replacement engine: DIP set dueling, PC signature counters and a
// per-set stream detector with dead-block marks; set state is kept in set-indexed RAMs.
// ----------------------------------------------------------------------------
// Sequencing: a victim query reads the set RAMs in READ and answers in VICTIM;
// an update reads in READ, evaluates in EVAL, then CTR_A writes the counter
// (hit) or the insertion point (fill) and CTR_B decrements the old signature
// counter of a fill. A new request is taken only in IDLE; a held response
// keeps the next victim query waiting. Every DECAY_PERIOD updates a dead-mark
// sweep over all sets precedes that update. After reset an init pass over all
// sets fills the RAMs with their reset rows; requests stall until it ends.
// ----------------------------------------------------------------------------
module hybrid_rrip_cache_replacement_unit import hrrip_pkg::*; #(
   parameter int NUM_SETS      = DEF_NUM_SETS,
   parameter int NUM_WAYS      = DEF_NUM_WAYS,
   parameter int LEADER_COUNT  = DEF_LEADER_COUNT,
   parameter int SELECTOR_BITS = DEF_SELECTOR_BITS,
   parameter int DECAY_PERIOD  = DEF_DECAY_PERIOD,
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_opcode,
   input  wire logic [SET_IN_W-1:0]   req_set_index,
   input  wire logic [WAY_IN_W-1:0]   req_way_index,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic [PC_W-1:0]       req_pc,
   input  wire logic                  req_hit,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [WAY_IN_W-1:0]   rsp_victim_way,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_write_data
);
   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int WAY_W   = $clog2(NUM_WAYS);
   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int DCY_W   = $clog2(DECAY_PERIOD);
   localparam int SIG_AW  = $clog2(SIG_DEPTH);
   // set row layout: rrpv | signatures | last address | sign history | pointer
   localparam int RRPV_BITS = NUM_WAYS * RRPV_W;
   localparam int SIG_LSB   = RRPV_BITS;
   localparam int LA_LSB    = SIG_LSB + NUM_WAYS * SIG_W;
   localparam int SG_LSB    = LA_LSB + ADDR_W;
   localparam int PT_LSB    = SG_LSB + HISTORY_DEPTH * 2;
   localparam int ROW_W     = PT_LSB + PTR_W;
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;
   localparam int LIP_END   = LEADER_COUNT / 2;
   localparam int BIP_START = NUM_SETS - LEADER_COUNT / 2;

   // wrap the request indexes into the configured geometry
   function automatic logic [SET_W-1:0] wrap_set(input logic [SET_IN_W-1:0] v);
      int r;
      r = int'(v);
      for (int k = 5; k >= 0; k--) begin
         if (r >= (NUM_SETS << k)) begin
            r = r - (NUM_SETS << k);
         end
      end
      return SET_W'(r);
   endfunction

   function automatic logic [WAY_W-1:0] wrap_way(input logic [WAY_IN_W-1:0] v);
      int r;
      r = int'(v);
      for (int k = 3; k >= 0; k--) begin
         if (r >= (NUM_WAYS << k)) begin
            r = r - (NUM_WAYS << k);
         end
      end
      return WAY_W'(r);
   endfunction

   state_type                 state_ff, state_in;
   logic [SET_W-1:0]          sweep_ff, sweep_in;
   logic                      sweep_last;

   logic                      op_ff, hit_ff;
   logic [SET_W-1:0]          set_ff;
   logic [WAY_W-1:0]          way_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [SIG_W-1:0]          sig_ff;
   logic                      decay_in;

   logic [DCY_W-1:0]          access_ff, access_in;
   logic [SELECTOR_BITS-1:0]  psel_ff, psel_in;
   logic [BIM_W-1:0]          bim_ff, bim_in;
   logic [1:0]                reuse_thr_ff;
   logic [CSR_DAT_W-1:0]      stream_thr_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WAY_IN_W-1:0]       rsp_way_ff, rsp_way_in;

   // fill bookkeeping held across the counter reads
   logic [ROW_W-1:0]          row_hold_ff, row_hold_in;
   logic [NUM_WAYS-1:0]       dead_hold_ff, dead_hold_in;
   logic [SIG_W-1:0]          old_sig_ff, old_sig_in;
   logic [RRPV_W-1:0]         ins_pre_ff, ins_pre_in;
   logic                      stream_ff, stream_in;

   // RAM ports
   logic                      row_rd_en, row_wr_en;
   logic [SET_W-1:0]          row_wr_addr;
   logic [ROW_W-1:0]          row_wr_data, row_rd_data;
   logic                      dead_wr_en;
   logic [NUM_WAYS-1:0]       dead_wr_data, dead_rd_data;
   logic                      ctr_rd_en, ctr_wr_en;
   logic [SIG_AW-1:0]         ctr_rd_addr, ctr_wr_addr;
   logic [CTR_W-1:0]          ctr_wr_data, ctr_rd_data;

   // row fields
   logic [NUM_WAYS-1:0][RRPV_W-1:0] row_rrpv, aged_rrpv;
   logic [NUM_WAYS-1:0][SIG_W-1:0]  row_sig;
   logic [HISTORY_DEPTH-1:0][1:0]   row_signs, signs_next;
   logic [PTR_W-1:0]                row_ptr, ptr_next;
   logic [ADDR_W-1:0]               row_last;
   logic [WAY_W-1:0]                vic_way;
   logic                            vic_age, streaming;
   logic [ROW_W-1:0]                init_row, upd_row;
   logic                            lip_lead, bip_lead, accept;
   logic [DCY_W-1:0]                access_inc;

   assign row_rrpv  = row_rd_data[RRPV_BITS-1:0];
   assign row_sig   = row_rd_data[LA_LSB-1:SIG_LSB];
   assign row_last  = row_rd_data[SG_LSB-1:LA_LSB];
   assign row_signs = row_rd_data[PT_LSB-1:SG_LSB];
   assign row_ptr   = row_rd_data[ROW_W-1:PT_LSB];

   assign accept     = req_valid && !req_stall;
   assign sweep_last = (sweep_ff == SET_W'(NUM_SETS - 1));
   assign lip_lead   = (int'(set_ff) < LIP_END);
   assign bip_lead   = (int'(set_ff) >= BIP_START);
   assign access_inc = (access_ff == DCY_W'(DECAY_PERIOD - 1)) ? '0 : access_ff + 1'b1;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

   hrrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (set_ff),
      .rd_data (row_rd_data)
   );

   hrrip_ram #(.WIDTH(NUM_WAYS), .DEPTH(NUM_SETS)) u_dead_ram (
      .clock   (clock),
      .wr_en   (dead_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (dead_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (set_ff),
      .rd_data (dead_rd_data)
   );

   hrrip_ram #(.WIDTH(CTR_W), .DEPTH(SIG_DEPTH)) u_ctr_ram (
      .clock   (clock),
      .wr_en   (ctr_wr_en),
      .wr_addr (ctr_wr_addr),
      .wr_data (ctr_wr_data),
      .rd_en   (ctr_rd_en),
      .rd_addr (ctr_rd_addr),
      .rd_data (ctr_rd_data)
   );

   hrrip_victim #(.NUM_WAYS(NUM_WAYS)) u_victim (
      .rrpv       (row_rrpv),
      .dead       (dead_rd_data),
      .victim_way (vic_way),
      .age        (vic_age),
      .aged_rrpv  (aged_rrpv)
   );

   hrrip_stream #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_stream (
      .address      (addr_ff),
      .last_address (row_last),
      .signs        (row_signs),
      .pointer      (row_ptr),
      .threshold    (stream_thr_ff),
      .signs_next   (signs_next),
      .pointer_next (ptr_next),
      .streaming    (streaming)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   if (sweep_last) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = decay_in ? ST_SWEEP : ST_READ;
         ST_SWEEP:  if (sweep_last) state_in = ST_READ;
         ST_READ:   state_in = (op_ff == OP_VICTIM) ? ST_VICTIM : ST_EVAL;
         ST_VICTIM: if (!(rsp_valid_ff && rsp_stall)) state_in = ST_IDLE;
         ST_EVAL:   state_in = ST_CTR_A;
         ST_CTR_A:  state_in = hit_ff ? ST_IDLE : ST_CTR_B;
         ST_CTR_B:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      sweep_in     = sweep_ff;
      decay_in     = 1'b0;
      access_in    = access_ff;
      psel_in      = psel_ff;
      bim_in       = bim_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_way_in   = rsp_way_ff;
      row_hold_in  = row_hold_ff;
      dead_hold_in = dead_hold_ff;
      old_sig_in   = old_sig_ff;
      ins_pre_in   = ins_pre_ff;
      stream_in    = stream_ff;
      row_rd_en    = 1'b0;
      row_wr_en    = 1'b0;
      row_wr_addr  = set_ff;
      row_wr_data  = row_rd_data;
      dead_wr_en   = 1'b0;
      dead_wr_data = dead_rd_data;
      ctr_rd_en    = 1'b0;
      ctr_rd_addr  = sig_ff;
      ctr_wr_en    = 1'b0;
      ctr_wr_addr  = old_sig_ff;
      ctr_wr_data  = ctr_rd_data;

      init_row = '0;
      init_row[RRPV_BITS-1:0] = '1;

      upd_row = row_rd_data;
      upd_row[LA_LSB +: ADDR_W]             = addr_ff;
      upd_row[SG_LSB +: HISTORY_DEPTH * 2]  = signs_next;
      upd_row[PT_LSB +: PTR_W]              = ptr_next;

      unique case (state_ff)
         ST_INIT: begin
            row_wr_en    = 1'b1;
            row_wr_addr  = sweep_ff;
            row_wr_data  = init_row;
            dead_wr_en   = 1'b1;
            dead_wr_data = '0;
            ctr_wr_en    = (int'(sweep_ff) < SIG_DEPTH);
            ctr_wr_addr  = sweep_ff[SIG_AW-1:0];
            ctr_wr_data  = CTR_INIT;
            sweep_in     = sweep_last ? '0 : sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept && (req_opcode == OP_UPDATE)) begin
               access_in = access_inc;
               decay_in  = (access_inc == '0);
            end
         end
         ST_SWEEP: begin
            // drop every dead mark, one set per cycle
            dead_wr_en   = 1'b1;
            row_wr_addr  = sweep_ff;
            dead_wr_data = '0;
            sweep_in     = sweep_last ? '0 : sweep_ff + 1'b1;
         end
         ST_READ: begin
            row_rd_en = 1'b1;
         end
         ST_VICTIM: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = WAY_IN_W'(vic_way);
               if (vic_age) begin
                  row_wr_en = 1'b1;
                  row_wr_data[RRPV_BITS-1:0] = aged_rrpv;
               end
            end
         end
         ST_EVAL: begin
            old_sig_in = row_sig[way_ff];
            stream_in  = streaming;
            ctr_rd_en  = 1'b1;
            if (hit_ff) begin
               ctr_rd_addr = row_sig[way_ff];
               row_wr_en   = 1'b1;
               row_wr_data = upd_row;
               row_wr_data[int'(way_ff) * RRPV_W +: RRPV_W] = RRPV_NEAR;
               dead_wr_en  = 1'b1;
               dead_wr_data[way_ff] = 1'b0;
               // a set in both leader groups counts up, then down
               if (lip_lead && (psel_in != SEL_MAX)) begin
                  psel_in = psel_in + 1'b1;
               end
               if (bip_lead && (psel_in != '0)) begin
                  psel_in = psel_in - 1'b1;
               end
            end else begin
               ctr_rd_addr = sig_ff;
               row_hold_in = upd_row;
               row_hold_in[SIG_LSB + int'(way_ff) * SIG_W +: SIG_W] = sig_ff;
               dead_hold_in = dead_rd_data;
               ins_pre_in   = RRPV_MAX;
               if (bip_lead || (!lip_lead && (psel_ff < SEL_MID))) begin
                  bim_in = bim_ff + 1'b1;
                  if (bim_in == '0) begin
                     ins_pre_in = RRPV_NEAR;
                  end
               end
            end
         end
         ST_CTR_A: begin
            if (hit_ff) begin
               ctr_wr_en   = 1'b1;
               ctr_wr_data = (ctr_rd_data == CTR_MAX) ? ctr_rd_data : ctr_rd_data + 1'b1;
            end else begin
               // insertion point, then read the victim signature counter
               row_wr_en    = 1'b1;
               row_wr_data  = row_hold_ff;
               dead_wr_en   = 1'b1;
               dead_wr_data = dead_hold_ff;
               if (stream_ff || (ctr_rd_data == '0)) begin
                  row_wr_data[int'(way_ff) * RRPV_W +: RRPV_W] = RRPV_MAX;
                  dead_wr_data[way_ff] = 1'b1;
               end else begin
                  row_wr_data[int'(way_ff) * RRPV_W +: RRPV_W] =
                     (ctr_rd_data > reuse_thr_ff) ? RRPV_NEAR : ins_pre_ff;
                  dead_wr_data[way_ff] = 1'b0;
               end
               ctr_rd_en   = 1'b1;
               ctr_rd_addr = old_sig_ff;
            end
         end
         ST_CTR_B: begin
            ctr_wr_en   = 1'b1;
            ctr_wr_data = (ctr_rd_data == '0) ? ctr_rd_data : ctr_rd_data - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         access_ff     <= '0;
         psel_ff       <= SEL_MID;
         bim_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         reuse_thr_ff  <= REUSE_RESET;
         stream_thr_ff <= STREAM_RESET;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         access_ff    <= access_in;
         psel_ff      <= psel_in;
         bim_ff       <= bim_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_REUSE:  reuse_thr_ff  <= csr_write_data[1:0];
               CSR_STREAM: stream_thr_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload: hold the request and the fill bookkeeping
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         hit_ff  <= req_hit;
         set_ff  <= wrap_set(req_set_index);
         way_ff  <= wrap_way(req_way_index);
         addr_ff <= req_address;
         sig_ff  <= req_pc[SIG_W-1:0] ^ req_pc[SIG_SHIFT +: SIG_W];
      end
      rsp_way_ff   <= rsp_way_in;
      row_hold_ff  <= row_hold_in;
      dead_hold_ff <= dead_hold_in;
      old_sig_ff   <= old_sig_in;
      ins_pre_ff   <= ins_pre_in;
      stream_ff    <= stream_in;
   end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hybrid RRIP replacement unit. Requests go in
// through a valid/stall channel. A scoreboard class runs its own model of the
// per-set RRPV, signature and stream state and keeps the victim ways it
// expects. Every victim returned on the response channel is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   import hrrip_pkg::*;

   localparam int  PERIOD      = 12;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 2200;   // covers a dead-mark sweep over all sets
   localparam int  NSETS       = DEF_NUM_SETS;
   localparam int  NWAYS       = DEF_NUM_WAYS;
   localparam int  LEADERS     = DEF_LEADER_COUNT;
   localparam int  PERIOD_UPD  = DEF_DECAY_PERIOD;
   localparam int  HDEPTH      = DEF_HISTORY_DEPTH;
   localparam logic [DEF_SELECTOR_BITS-1:0] SEL_TOP = '1;
   localparam logic [DEF_SELECTOR_BITS-1:0] SEL_HALF = SEL_TOP >> 1;

   typedef struct {
      opcode_type          op;
      logic [SET_IN_W-1:0] set_idx;
      logic [WAY_IN_W-1:0] way_idx;
      logic [ADDR_W-1:0]   addr;
      logic [PC_W-1:0]     pc;
      logic                hit;
   } access_req_type;

   // -------------------------------------------------------------------------
   // Scoreboard: replacement-state model plus the queue of expected victims
   // -------------------------------------------------------------------------
   class victim_scoreboard;
      logic [RRPV_W-1:0] rrpv_mem [NSETS*NWAYS];
      logic [SIG_W-1:0]  sig_mem  [NSETS*NWAYS];
      logic              dead_mem [NSETS*NWAYS];
      logic [CTR_W-1:0]  sig_ctr  [SIG_DEPTH];
      logic [ADDR_W-1:0] prev_addr [NSETS];
      sign_code_type     signs    [NSETS][HDEPTH];
      int                hist_ptr [NSETS];
      logic [DEF_SELECTOR_BITS-1:0] psel;
      int                upd_count;
      logic [BIM_W-1:0]  bim_count;
      logic [1:0]        reuse_thr;
      logic [2:0]        stream_thr;
      logic [WAY_IN_W-1:0] victims_due [$];
      int                errors;

      function new();
         foreach (rrpv_mem[i]) begin
            rrpv_mem[i] = RRPV_MAX;
            sig_mem[i]  = '0;
            dead_mem[i] = 1'b0;
         end
         foreach (sig_ctr[i]) sig_ctr[i] = CTR_INIT;
         foreach (prev_addr[s]) begin
            prev_addr[s] = '0;
            hist_ptr[s]  = 0;
            for (int h = 0; h < HDEPTH; h++) signs[s][h] = CODE_ZERO;
         end
         psel       = SEL_HALF;
         upd_count  = 0;
         bim_count  = '0;
         reuse_thr  = REUSE_RESET;
         stream_thr = STREAM_RESET;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
         if (idx == CSR_REUSE) reuse_thr = value[1:0];
         else stream_thr = value;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // Record the delta sign for the set and say whether it now streams.
      function bit track_stream(int s, logic [ADDR_W-1:0] a);
         int pos, neg;
         sign_code_type code;
         pos = 0;
         neg = 0;
         if (prev_addr[s] != '0) begin
            code = CODE_ZERO;
            if (a > prev_addr[s]) code = CODE_POS;
            else if (a < prev_addr[s]) code = CODE_NEG;
            signs[s][hist_ptr[s]] = code;
            hist_ptr[s] = (hist_ptr[s] + 1) % HDEPTH;
         end
         prev_addr[s] = a;
         for (int h = 0; h < HDEPTH; h++) begin
            if (signs[s][h] == CODE_POS) pos++;
            else if (signs[s][h] == CODE_NEG) neg++;
         end
         return (pos + neg) >= stream_thr && (pos >= stream_thr || neg >= stream_thr);
      endfunction

      function logic [WAY_IN_W-1:0] choose_victim(int s);
         int base;
         base = s * NWAYS;
         for (int w = 0; w < NWAYS; w++) if (dead_mem[base+w]) return WAY_IN_W'(w);
         for (int w = 0; w < NWAYS; w++)
            if (rrpv_mem[base+w] == RRPV_MAX) return WAY_IN_W'(w);
         for (int w = 0; w < NWAYS; w++)
            if (rrpv_mem[base+w] < RRPV_MAX) rrpv_mem[base+w]++;
         for (int w = 0; w < NWAYS; w++)
            if (rrpv_mem[base+w] == RRPV_MAX) return WAY_IN_W'(w);
         return '0;
      endfunction

      function void apply_access(int s, int w, logic [ADDR_W-1:0] a, logic [PC_W-1:0] pc,
                                 logic hit);
         int idx;
         bit lip_lead, bip_lead, streaming;
         logic [SIG_W-1:0] sig, old_sig;
         logic [RRPV_W-1:0] ins;
         logic [PC_W-1:0] mixed;
         idx      = s * NWAYS + w;
         lip_lead = s < LEADERS / 2;
         bip_lead = s >= NSETS - LEADERS / 2;
         upd_count = (upd_count + 1) % PERIOD_UPD;
         if (upd_count == 0) foreach (dead_mem[i]) dead_mem[i] = 1'b0;
         streaming = track_stream(s, a);
         mixed = pc ^ (pc >> SIG_SHIFT);
         sig   = mixed[SIG_W-1:0];
         if (hit) begin
            rrpv_mem[idx] = RRPV_NEAR;
            dead_mem[idx] = 1'b0;
            if (sig_ctr[sig_mem[idx]] < CTR_MAX) sig_ctr[sig_mem[idx]]++;
            if (lip_lead && psel < SEL_TOP) psel++;
            if (bip_lead && psel > 0) psel--;
            return;
         end
         old_sig      = sig_mem[idx];
         sig_mem[idx] = sig;
         ins = RRPV_MAX;
         if (bip_lead || (!lip_lead && psel < SEL_HALF)) begin
            bim_count++;
            if (bim_count == '0) ins = RRPV_NEAR;
         end
         if (sig_ctr[sig] > reuse_thr) ins = RRPV_NEAR;
         if (streaming || sig_ctr[sig] == '0) begin
            ins = RRPV_MAX;
            dead_mem[idx] = 1'b1;
         end else begin
            dead_mem[idx] = 1'b0;
         end
         rrpv_mem[idx] = ins;
         if (sig_ctr[old_sig] > 0) sig_ctr[old_sig]--;
      endfunction

      function void note_request(access_req_type r);
         if (r.op == OP_VICTIM) victims_due.push_back(choose_victim(int'(r.set_idx)));
         else apply_access(int'(r.set_idx), int'(r.way_idx), r.addr, r.pc, r.hit);
      endfunction

      task check_victim(logic [WAY_IN_W-1:0] got);
         logic [WAY_IN_W-1:0] want;
         if (victims_due.size() == 0) begin
            report_mismatch($sformatf("victim way %0d with none expected", got));
         end else begin
            want = victims_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("victim_way got %0d want %0d", got, want));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic [SET_IN_W-1:0] req_set_index = '0;
   logic [WAY_IN_W-1:0] req_way_index = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [PC_W-1:0]     req_pc = '0;
   logic                req_hit = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [WAY_IN_W-1:0] rsp_victim_way;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_write_data = '0;

   always #(PERIOD/2) clock = ~clock;

   hybrid_rrip_cache_replacement_unit i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_set_index, .req_way_index,
      .req_address, .req_pc, .req_hit,
      .rsp_valid, .rsp_stall, .rsp_victim_way,
      .csr_write_en, .csr_index, .csr_write_data
   );

   victim_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int cycles        = 0;

   // Abort on a hang; any state at that point is a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: drive stall at the falling edge, a long hold-off has
   // priority over random stalls; check each transfer at the rising edge.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_victim(rsp_victim_way);

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   logic [SET_IN_W-1:0] set_pool [8];
   logic [PC_W-1:0]     pc_pool [8];
   logic [ADDR_W-1:0]   stream_addr;
   bit                  stream_up;

   // Hold the payload until the transfer, then advance to the next falling edge.
   task automatic send_req(access_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_opcode    = r.op;
      req_set_index = r.set_idx;
      req_way_index = r.way_idx;
      req_address   = r.addr;
      req_pc        = r.pc;
      req_hit       = r.hit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.victims_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en   = 1'b0;
      sb.write_reg(idx, value);
   endtask

   function automatic access_req_type mk_req(opcode_type op, int s, int w,
                                             logic [ADDR_W-1:0] a, logic [PC_W-1:0] pc,
                                             logic hit);
      access_req_type r;
      r.op = op; r.set_idx = SET_IN_W'(s); r.way_idx = WAY_IN_W'(w);
      r.addr = a; r.pc = pc; r.hit = hit;
      return r;
   endfunction

   // Mostly a few hot sets and PCs with streaming addresses, so that
   // signatures, leaders and stream marks interact; the rest is noise.
   function automatic access_req_type random_req(bit updates_only);
      access_req_type r;
      r.op      = (updates_only || $urandom_range(99) < 60) ? OP_UPDATE : OP_VICTIM;
      r.set_idx = ($urandom_range(99) < 85) ? set_pool[$urandom_range(7)]
                                            : SET_IN_W'($urandom);
      r.way_idx = WAY_IN_W'($urandom);
      r.pc      = ($urandom_range(99) < 80) ? pc_pool[$urandom_range(7)]
                                            : {$urandom, $urandom};
      r.hit     = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) stream_up = !stream_up;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            stream_addr = stream_up ? stream_addr + 64 : stream_addr - 64;
            r.addr = stream_addr;
         end
         6, 7: r.addr = ADDR_W'({$urandom, $urandom});
         8: r.addr = '0;
         default: r.addr = '1;
      endcase
      return r;
   endfunction

   task automatic run_random(int count, bit updates_only);
      for (int i = 0; i < count; i++) send_req(random_req(updates_only));
   endtask

   initial begin
      set_pool = '{0, 31, 32, 1000, 2015, 2016, 2047, SET_IN_W'($urandom)};
      foreach (pc_pool[i]) pc_pool[i] = {$urandom, $urandom};
      stream_addr = ADDR_W'({$urandom, $urandom});
      stream_up   = 1'b1;

      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);   // init pass of the set RAMs
      @(negedge clock);

      // Directed: promote every way of one set, then force the aging path.
      for (int w = 0; w < NWAYS; w++)
         send_req(mk_req(OP_UPDATE, 5, w, 48'h1000, 64'h40, 1'b1));
      repeat (3) send_req(mk_req(OP_VICTIM, 5, 0, '0, '0, 1'b0));
      send_req(mk_req(OP_UPDATE, 2047, 15, '1, '1, 1'b0));
      send_req(mk_req(OP_UPDATE, 0, 0, 48'h2000, 64'h1234, 1'b0));
      send_req(mk_req(OP_UPDATE, 0, 0, 48'h3000, 64'h1234, 1'b1));
      send_req(mk_req(OP_UPDATE, 2047, 15, 48'h10, '1, 1'b1));
      send_req(mk_req(OP_VICTIM, 2047, 0, '0, '0, 1'b0));
      send_req(mk_req(OP_VICTIM, 0, 0, '0, '0, 1'b0));
      drain();

      // Phase 1: lowest thresholds (every set streams), sender idles little.
      write_reg(CSR_REUSE, 3'b100);
      write_reg(CSR_STREAM, 3'b000);
      send_idle_pct = 13;
      recv_idle_pct = 52;
      run_random(560, 0);
      drain();

      // Phase 2: highest useful thresholds, receiver idles little.
      write_reg(CSR_REUSE, 3'b011);
      write_reg(CSR_STREAM, 3'b100);
      send_idle_pct = 52;
      recv_idle_pct = 13;
      run_random(560, 0);
      drain();

      // Phase 3: no idling; a long hold-off first fills the block.
      write_reg(CSR_REUSE, 3'b001);
      write_reg(CSR_STREAM, 3'b111);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 400;
      run_random(560, 0);
      drain();

      // Phase 4: mid thresholds, mixed traffic.
      write_reg(CSR_REUSE, 3'b010);
      write_reg(CSR_STREAM, 3'b010);
      run_random(100, 0);

      req_valid = 1'b0;
      while (sb.victims_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
